>>> rtl/pkcs7_signed_data_der_walker_assert.svh
// Assertion macros shared by the DER walker RTL.
`ifndef PKCS7_SIGNED_DATA_DER_WALKER_ASSERT_SVH
`define PKCS7_SIGNED_DATA_DER_WALKER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define P7SDW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define P7SDW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/p7sdw_pkg.sv
// Types, schema tables and walk helpers for the DER walker.
package p7sdw_pkg;

	localparam int unsigned MAX_LENGTH_BYTES = 4;

	localparam logic [4:0] STEP_CERTS = 5'd5;
	localparam logic [4:0] STEP_CRLS  = 5'd19;
	localparam logic [4:0] STEP_FINAL = 5'd29;
	localparam logic [4:0] STEP_OUTER = 5'd30;

	localparam logic [7:0] TAG_CTX0_CONS = 8'hA0;
	localparam logic [7:0] TAG_CTX1_CONS = 8'hA1;
	localparam logic [7:0] TAG_CLASS_MASK = 8'hC0;
	localparam logic [7:0] TAG_CLASS_CTX = 8'h80;

	typedef enum logic [7:0] {
		PH_TAG      = 8'b0000_0001,
		PH_WRAPLEN1 = 8'b0000_0010,
		PH_WRAPLENX = 8'b0000_0100,
		PH_ELEMTAG  = 8'b0000_1000,
		PH_LEN1     = 8'b0001_0000,
		PH_LENX     = 8'b0010_0000,
		PH_LENDROP  = 8'b0100_0000,
		PH_SKIP     = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		W_NONE = 3'd0,
		W_ANY  = 3'd1,
		W_A0   = 3'd2,
		W_CTX0 = 3'd3,
		W_A1   = 3'd4
	} wrap_t;

	typedef enum logic [1:0] {
		KIND_ELEM = 2'd0,
		KIND_OK   = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

	typedef struct packed {
		logic norec;
		logic opt;
		logic desc;
		logic bound;
	} flags_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  id;
		logic [7:0]  tag;
		logic [31:0] begin_off;
		logic [31:0] len;
		logic [1:0]  level;
	} res_t;

	typedef struct packed {
		logic [4:0] s;
		phase_t     ph;
		logic       concl;
		logic       ok;
	} settle_t;

	typedef struct packed {
		logic [4:0] s;
		phase_t     ph;
		logic       fail;
		logic       held;
	} resolve_t;

	function automatic logic [7:0] step_tag(input logic [4:0] s);
		logic [7:0] t;
		case (s) inside
			5'd0:                  t = 8'h06;
			5'd2, 5'd7, 5'd8, 5'd22: t = 8'h02;
			5'd3, 5'd20:           t = 8'h31;
			5'd14, 5'd28:          t = 8'hA1;
			5'd15:                 t = 8'hA2;
			5'd16:                 t = 8'hA3;
			5'd18:                 t = 8'h03;
			5'd25:                 t = 8'hA0;
			5'd27:                 t = 8'h04;
			5'd29, 5'd31:          t = 8'h00;
			default:               t = 8'h30;
		endcase
		return t;
	endfunction

	function automatic logic [1:0] step_level(input logic [4:0] s);
		logic [1:0] l;
		case (s) inside
			[5'd2:5'd5], 5'd19, 5'd20:  l = 2'd1;
			5'd6, 5'd17, 5'd18, 5'd21:  l = 2'd2;
			[5'd7:5'd16], [5'd22:5'd28]: l = 2'd3;
			default:                    l = 2'd0;
		endcase
		return l;
	endfunction

	function automatic flags_t step_flags(input logic [4:0] s);
		flags_t f;
		f = '0;
		case (s) inside
			5'd1:                                f.desc = 1'b1;
			5'd2, 5'd3, 5'd4, 5'd7, 5'd17, 5'd18,
			5'd19, 5'd22, 5'd23, 5'd24, 5'd26, 5'd27: f.bound = 1'b1;
			5'd5, 5'd6, 5'd20, 5'd21: begin
				f.bound = 1'b1;
				f.desc  = 1'b1;
			end
			5'd14, 5'd15, 5'd16:                 f.opt = 1'b1;
			5'd25, 5'd28: begin
				f.bound = 1'b1;
				f.opt   = 1'b1;
			end
			5'd30: begin
				f.bound = 1'b1;
				f.desc  = 1'b1;
				f.norec = 1'b1;
			end
			default:                             f = '0;
		endcase
		return f;
	endfunction

	function automatic wrap_t step_wrap(input logic [4:0] s);
		wrap_t w;
		case (s)
			5'd1:    w = W_ANY;
			5'd5:    w = W_A0;
			5'd7:    w = W_CTX0;
			5'd19:   w = W_A1;
			default: w = W_NONE;
		endcase
		return w;
	endfunction

	function automatic logic [4:0] step_after(input logic [4:0] s);
		return (s == STEP_OUTER) ? 5'd0 : s + 5'd1;
	endfunction

	function automatic logic [4:0] step_on_miss(input logic [4:0] s);
		return (s == STEP_CERTS) ? STEP_CRLS : s + 5'd1;
	endfunction

	function automatic logic may_miss(input logic [4:0] s);
		wrap_t w;
		w = step_wrap(s);
		return step_flags(s).opt || w == W_A0 || w == W_CTX0 || w == W_A1;
	endfunction

	function automatic logic wrap_hit(input wrap_t w, input logic [7:0] b);
		logic h;
		case (w)
			W_ANY:   h = 1'b1;
			W_A0:    h = (b == TAG_CTX0_CONS);
			W_A1:    h = (b == TAG_CTX1_CONS);
			W_CTX0:  h = ((b & TAG_CLASS_MASK) == TAG_CLASS_CTX) && (b[4:0] == 5'd0);
			default: h = 1'b0;
		endcase
		return h;
	endfunction

	// Advance through steps that need no byte: final check, empty skips, absent options.
	function automatic settle_t settle(input logic [4:0] s_in, input phase_t ph_in,
		input logic skip_zero, input logic lt, input logic eq);
		settle_t r;
		logic    done;
		r.s = s_in;
		r.ph = ph_in;
		r.concl = 1'b0;
		r.ok = 1'b0;
		done = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (!done) begin
				if (r.s == STEP_FINAL) begin
					r.concl = 1'b1;
					r.ok = eq;
					done = 1'b1;
				end else if (r.ph == PH_SKIP && skip_zero) begin
					r.s = step_after(r.s);
					r.ph = PH_TAG;
				end else if (lt) begin
					done = 1'b1;
				end else if (r.ph == PH_TAG && may_miss(r.s)) begin
					r.s = step_on_miss(r.s);
				end else begin
					r.concl = 1'b1;
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Try the tag byte against the current step and any optional steps after it.
	function automatic resolve_t resolve(input logic [4:0] s_in, input logic [7:0] b);
		resolve_t r;
		logic     done;
		wrap_t    w;
		r.s = s_in;
		r.ph = PH_TAG;
		r.fail = 1'b0;
		r.held = 1'b0;
		done = 1'b0;
		for (int i = 0; i < 5; i++) begin
			w = step_wrap(r.s);
			if (!done) begin
				if (r.s == STEP_FINAL) begin
					r.fail = 1'b1;
					done = 1'b1;
				end else if (w != W_NONE) begin
					if (wrap_hit(w, b)) begin
						r.ph = PH_WRAPLEN1;
						done = 1'b1;
					end else begin
						r.s = step_on_miss(r.s);
					end
				end else if (b == step_tag(r.s)) begin
					r.ph = PH_LEN1;
					r.held = 1'b1;
					done = 1'b1;
				end else if (step_flags(r.s).opt) begin
					r.s = step_after(r.s);
				end else begin
					r.fail = 1'b1;
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/pkcs7_signed_data_der_walker.sv
// Streaming walker of a DER signedData blob with an APB length register.
//
// Feed the blob one byte per transfer, start_of_message set on byte 0, after writing its
// total length to message_length (address 0). Each byte sits in an input register, one
// pass of compare and shift-add logic walks the schema, and the records load from there
// into a two-entry result buffer once it has room, from which they transfer out. A byte
// that yields both an element record and the final record holds the input while the
// buffer drains; otherwise one byte is taken every cycle while the result buffer has
// room. Output tuser is result_kind: 0 element record, 1 success, 2 failure; a walk
// ends with one of the last two, and bytes after that are dropped until the next start.
`include "pkcs7_signed_data_der_walker_assert.svh"

module pkcs7_signed_data_der_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] start_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] element_id, [12:5] element_tag, [44:13] begin_offset,
	// [76:45] element_length, [78:77] nesting_level, [79] zero
	output logic [79:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] result_kind
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] mlen_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	logic [31:0]         pos_q;
	logic [4:0]          step_q;
	p7sdw_pkg::phase_t   phase_q;
	logic [31:0]         acc_q;
	logic [6:0]          lbl_q;
	logic [31:0]         skip_q;
	logic [7:0]          held_q;
	logic                fin_q;

	p7sdw_pkg::res_t res0_q, res1_q;
	logic [1:0]      cnt_q;

	logic pop, room, fire;

	logic [31:0]         e_pos, n_pos, e_acc, n_acc, e_skip, n_skip, hd_len;
	logic [4:0]          e_step, n_step;
	p7sdw_pkg::phase_t   e_ph, n_ph;
	logic [6:0]          e_lbl, n_lbl;
	logic [7:0]          e_held, n_held;
	logic                e_fin, n_fin;
	logic                lt0, hd, concl_v, concl_ok, rec_v;
	logic [32:0]         end_sum;
	p7sdw_pkg::settle_t  pre, post;
	p7sdw_pkg::resolve_t rsv;
	p7sdw_pkg::flags_t   hfl;
	p7sdw_pkg::res_t     rec, conc, first;

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? mlen_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mlen_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			mlen_q <= pwdata;
		end
	end

	// Handshake between input register and result buffer
	assign pop = m_axis_tvalid && m_axis_tready;
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
	assign fire = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire;

	// Capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Walk one byte
	always_comb begin
		e_pos = start_s1 ? 32'd0 : pos_q;
		e_step = start_s1 ? p7sdw_pkg::STEP_OUTER : step_q;
		e_ph = start_s1 ? p7sdw_pkg::PH_TAG : phase_q;
		e_acc = start_s1 ? 32'd0 : acc_q;
		e_lbl = start_s1 ? 7'd0 : lbl_q;
		e_skip = start_s1 ? 32'd0 : skip_q;
		e_held = start_s1 ? 8'd0 : held_q;
		e_fin = start_s1 ? 1'b0 : fin_q;

		n_pos = e_pos;
		n_step = e_step;
		n_ph = e_ph;
		n_acc = e_acc;
		n_lbl = e_lbl;
		n_skip = e_skip;
		n_held = e_held;
		n_fin = e_fin;
		hd = 1'b0;
		hd_len = 32'd0;
		concl_v = 1'b0;
		concl_ok = 1'b0;
		rec_v = 1'b0;
		hfl = '0;
		end_sum = '0;
		rsv = '0;
		post = '0;

		lt0 = e_pos < mlen_q;
		pre = p7sdw_pkg::settle(e_step, e_ph, e_skip == 32'd0, lt0, e_pos == mlen_q);

		if (!e_fin) begin
			n_step = pre.s;
			n_ph = pre.ph;
			if (pre.concl) begin
				concl_v = 1'b1;
				concl_ok = pre.ok;
			end else begin
				// consume the byte in the current header phase
				unique case (pre.ph)
					p7sdw_pkg::PH_TAG: begin
						rsv = p7sdw_pkg::resolve(pre.s, byte_s1);
						n_step = rsv.s;
						if (rsv.fail) begin
							concl_v = 1'b1;
						end else begin
							n_pos = e_pos + 32'd1;
							n_ph = rsv.ph;
							if (rsv.held) begin
								n_held = byte_s1;
							end
						end
					end
					p7sdw_pkg::PH_ELEMTAG: begin
						if (byte_s1 == p7sdw_pkg::step_tag(pre.s)) begin
							n_pos = e_pos + 32'd1;
							n_held = byte_s1;
							n_ph = p7sdw_pkg::PH_LEN1;
						end else begin
							concl_v = 1'b1;
						end
					end
					p7sdw_pkg::PH_WRAPLEN1: begin
						n_pos = e_pos + 32'd1;
						if (byte_s1[7] && byte_s1[6:0] != 7'd0) begin
							n_lbl = byte_s1[6:0];
							n_ph = p7sdw_pkg::PH_WRAPLENX;
						end else begin
							n_ph = p7sdw_pkg::PH_ELEMTAG;
						end
					end
					p7sdw_pkg::PH_WRAPLENX: begin
						n_pos = e_pos + 32'd1;
						n_lbl = e_lbl - 7'd1;
						if (n_lbl == 7'd0) begin
							n_ph = p7sdw_pkg::PH_ELEMTAG;
						end
					end
					p7sdw_pkg::PH_LEN1: begin
						n_pos = e_pos + 32'd1;
						n_acc = 32'd0;
						if (byte_s1[7]) begin
							n_lbl = byte_s1[6:0];
							if (n_lbl == 7'd0) begin
								hd = 1'b1;
							end else if (n_lbl > 7'(p7sdw_pkg::MAX_LENGTH_BYTES)) begin
								n_ph = p7sdw_pkg::PH_LENDROP;
							end else begin
								n_ph = p7sdw_pkg::PH_LENX;
							end
						end else begin
							n_acc = {24'd0, byte_s1};
							hd = 1'b1;
						end
					end
					p7sdw_pkg::PH_LENX: begin
						n_pos = e_pos + 32'd1;
						n_acc = {e_acc[23:0], byte_s1};
						n_lbl = e_lbl - 7'd1;
						hd = (n_lbl == 7'd0);
					end
					p7sdw_pkg::PH_LENDROP: begin
						n_pos = e_pos + 32'd1;
						n_lbl = e_lbl - 7'd1;
						if (n_lbl == 7'd0) begin
							n_acc = 32'd0;
							hd = 1'b1;
						end
					end
					p7sdw_pkg::PH_SKIP: begin
						n_pos = e_pos + 32'd1;
						n_skip = e_skip - 32'd1;
					end
					default: begin
						concl_v = 1'b1;
					end
				endcase

				// close the element header: record, bound check, descend or skip
				if (hd) begin
					hd_len = n_acc;
					hfl = p7sdw_pkg::step_flags(n_step);
					rec_v = !hfl.norec;
					end_sum = {1'b0, n_pos} + {1'b0, hd_len};
					if (hfl.bound && end_sum > {1'b0, mlen_q}) begin
						if (hfl.opt) begin
							n_step = p7sdw_pkg::step_after(n_step);
							n_ph = p7sdw_pkg::PH_TAG;
						end else begin
							concl_v = 1'b1;
						end
					end else if (hfl.desc) begin
						n_step = p7sdw_pkg::step_after(n_step);
						n_ph = p7sdw_pkg::PH_TAG;
					end else begin
						n_skip = hd_len;
						n_ph = p7sdw_pkg::PH_SKIP;
					end
				end

				// settle what follows the byte without consuming another
				if (!concl_v) begin
					post = p7sdw_pkg::settle(n_step, n_ph, n_skip == 32'd0,
						n_pos < mlen_q, n_pos == mlen_q);
					n_step = post.s;
					n_ph = post.ph;
					concl_v = post.concl;
					concl_ok = post.ok;
				end
			end
			if (concl_v) begin
				n_fin = 1'b1;
			end
		end
	end

	// Build the records of this byte
	always_comb begin
		rec.kind = p7sdw_pkg::KIND_ELEM;
		rec.id = n_step;
		rec.tag = n_held;
		rec.begin_off = n_pos;
		rec.len = hd_len;
		rec.level = p7sdw_pkg::step_level(n_step);
		if (hd) begin
			rec.id = pre.s;
			rec.level = p7sdw_pkg::step_level(pre.s);
		end
		conc = '0;
		conc.kind = concl_ok ? p7sdw_pkg::KIND_OK : p7sdw_pkg::KIND_FAIL;
		first = rec_v ? rec : conc;
	end

	// Hold walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			step_q <= p7sdw_pkg::STEP_OUTER;
			phase_q <= p7sdw_pkg::PH_TAG;
			acc_q <= '0;
			lbl_q <= '0;
			skip_q <= '0;
			held_q <= '0;
			fin_q <= 1'b1;
		end else if (fire) begin
			pos_q <= n_pos;
			step_q <= n_step;
			phase_q <= n_ph;
			acc_q <= n_acc;
			lbl_q <= n_lbl;
			skip_q <= n_skip;
			held_q <= n_held;
			fin_q <= n_fin;
		end
	end

	// Result buffer: load on a walked byte, advance on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= {1'b0, rec_v} + {1'b0, concl_v};
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res0_q <= first;
			res1_q <= conc;
		end else if (pop) begin
			res0_q <= res1_q;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tuser = res0_q.kind;
	assign m_axis_tdata = {1'b0, res0_q.level, res0_q.len, res0_q.begin_off, res0_q.tag,
		res0_q.id};

	`P7SDW_NEVER(a_cnt_range, cnt_q == 2'd3, "result buffer count out of range")
	`P7SDW_ASSERT(a_concl_ends, fire && concl_v |=> fin_q, "walk not ended after final record")
	`P7SDW_NEVER(a_no_idle_skip, !fin_q && phase_q == p7sdw_pkg::PH_SKIP && skip_q == 32'd0,
		"empty skip left pending")

endmodule
